// ===== hdl/cat_pkg.sv =====
// shared types, codes and neighbor offset table of the active cell tracker
package cat_pkg;

  // operation codes of an input word
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_ADD_NB  = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_COMMIT  = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  // status codes of a result word
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OUTSIDE    = 2'd1;
  localparam logic [1:0] ST_NB_INVALID = 2'd2;
  localparam logic [1:0] ST_ENTRY      = 2'd3;

  // neighborhood kinds
  localparam logic [1:0] KIND_VN      = 2'd0;
  localparam logic [1:0] KIND_MOORE   = 2'd1;
  localparam logic [1:0] KIND_HEX_COL = 2'd2;
  localparam logic [1:0] KIND_HEX_ROW = 2'd3;

  localparam logic [3:0] HEX_SHIFT = 4'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_KIND     = 2'd0;
  localparam logic [1:0] CFG_TOROIDAL = 2'd1;
  localparam logic [1:0] CFG_ROWS     = 2'd2;
  localparam logic [1:0] CFG_COLS     = 2'd3;

  // command kinds passed from front to back
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_CLR    = 3'd2;
  localparam logic [2:0] CMD_COMMIT = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [3:0]  neighbor_index;
    logic [11:0] entry_index;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  target_row;
    logic [5:0]  target_col;
    logic [1:0]  status;
    logic        changed;
    logic [12:0] pending_count;
    logic [12:0] current_count;
  } out_word_t;

  // effective configuration, grid sizes already clamped
  typedef struct packed {
    logic [1:0] kind;
    logic       toroidal;
    logic [6:0] rows;
    logic [6:0] cols;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [1:0]  status;
    logic [11:0] entry;
  } cmd_t;

  typedef struct packed {
    logic signed [1:0] dr;
    logic signed [1:0] dc;
  } offset_t;

  function automatic offset_t mk_off(input int dr, input int dc);
    offset_t o;
    o.dr = 2'(dr);
    o.dc = 2'(dc);
    return o;
  endfunction

  // k already includes the parity shift for the hex kinds
  function automatic offset_t nb_offset(input logic [1:0] kind, input logic [3:0] k);
    offset_t o;
    o = mk_off(0, 0);
    case (kind)
      KIND_VN, KIND_MOORE: begin
        case (k)
          4'd1: o = mk_off(-1, 0);
          4'd2: o = mk_off(0, -1);
          4'd3: o = mk_off(0, 1);
          4'd4: o = mk_off(1, 0);
          4'd5: o = mk_off(-1, -1);
          4'd6: o = mk_off(1, -1);
          4'd7: o = mk_off(1, 1);
          4'd8: o = mk_off(-1, 1);
          default: o = mk_off(0, 0);
        endcase
      end
      KIND_HEX_COL: begin
        case (k)
          4'd1:  o = mk_off(-1, 1);
          4'd2:  o = mk_off(-1, 0);
          4'd3:  o = mk_off(-1, -1);
          4'd4:  o = mk_off(0, -1);
          4'd5:  o = mk_off(1, 0);
          4'd6:  o = mk_off(0, 1);
          4'd8:  o = mk_off(0, 1);
          4'd9:  o = mk_off(-1, 0);
          4'd10: o = mk_off(0, -1);
          4'd11: o = mk_off(1, -1);
          4'd12: o = mk_off(1, 0);
          4'd13: o = mk_off(1, 1);
          default: o = mk_off(0, 0);
        endcase
      end
      default: begin
        case (k)
          4'd1:  o = mk_off(-1, 0);
          4'd2:  o = mk_off(-1, -1);
          4'd3:  o = mk_off(0, -1);
          4'd4:  o = mk_off(1, -1);
          4'd5:  o = mk_off(1, 0);
          4'd6:  o = mk_off(0, 1);
          4'd8:  o = mk_off(-1, 1);
          4'd9:  o = mk_off(-1, 0);
          4'd10: o = mk_off(0, -1);
          4'd11: o = mk_off(1, 0);
          4'd12: o = mk_off(1, 1);
          4'd13: o = mk_off(0, 1);
          default: o = mk_off(0, 0);
        endcase
      end
    endcase
    return o;
  endfunction

endpackage

// ===== hdl/cat_ram.sv =====
// generic single write port ram with registered read
module cat_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/cat_front.sv =====
// front end: accepts input words, resolves neighbor coordinates and status
module cat_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  cat_pkg::in_word_t in_data,
  input  cat_pkg::cfg_t     cfg,
  input  logic              busy,
  output logic              push_valid,
  input  logic              push_ready,
  output cat_pkg::cmd_t     push_data
);

  logic [3:0]        size_v;
  logic [3:0]        k;
  logic              odd_sel;
  cat_pkg::offset_t  off;
  logic signed [7:0] rows_s, cols_s, nr, nc;
  logic              off_grid, nb_bad, flat_out;

  assign in_ready   = push_ready && !busy;
  assign push_valid = in_valid && !busy;

  always_comb begin
    push_data       = '0;
    push_data.kind  = cat_pkg::CMD_NONE;
    push_data.status = cat_pkg::ST_OK;
    push_data.entry = in_data.entry_index;

    case (cfg.kind)
      cat_pkg::KIND_VN:    size_v = 4'd5;
      cat_pkg::KIND_MOORE: size_v = 4'd9;
      default:             size_v = 4'd7;
    endcase
    odd_sel = (cfg.kind == cat_pkg::KIND_HEX_COL && in_data.col[0]) ||
              (cfg.kind == cat_pkg::KIND_HEX_ROW && in_data.row[0]);
    k   = in_data.neighbor_index + (odd_sel ? cat_pkg::HEX_SHIFT : 4'd0);
    off = cat_pkg::nb_offset(cfg.kind, k);

    rows_s = $signed({1'b0, cfg.rows});
    cols_s = $signed({1'b0, cfg.cols});
    nr = $signed({2'b00, in_data.row}) + $signed({{6{off.dr[1]}}, off.dr});
    nc = $signed({2'b00, in_data.col}) + $signed({{6{off.dc[1]}}, off.dc});
    // offsets are one step, so a wrap is at most one grid length
    if (cfg.toroidal) begin
      if (nr < 0) begin
        nr = rows_s - 8'sd1;
      end else if (nr >= rows_s) begin
        nr = 8'sd0;
      end
      if (nc < 0) begin
        nc = cols_s - 8'sd1;
      end else if (nc >= cols_s) begin
        nc = 8'sd0;
      end
    end

    off_grid = ({1'b0, in_data.row} >= cfg.rows) || ({1'b0, in_data.col} >= cfg.cols);
    nb_bad   = in_data.neighbor_index >= size_v;
    flat_out = (nr < 0) || (nc < 0) || (nr >= rows_s) || (nc >= cols_s);

    case (in_data.operation)
      cat_pkg::OP_ADD, cat_pkg::OP_REMOVE: begin
        if (off_grid) begin
          push_data.status = cat_pkg::ST_OUTSIDE;
        end else begin
          push_data.kind = (in_data.operation == cat_pkg::OP_ADD) ?
                           cat_pkg::CMD_SET : cat_pkg::CMD_CLR;
          push_data.row  = in_data.row;
          push_data.col  = in_data.col;
        end
      end
      cat_pkg::OP_ADD_NB: begin
        if (off_grid) begin
          push_data.status = cat_pkg::ST_OUTSIDE;
        end else if (nb_bad) begin
          push_data.status = cat_pkg::ST_NB_INVALID;
        end else if (flat_out) begin
          push_data.status = cat_pkg::ST_OUTSIDE;
        end else begin
          push_data.kind = cat_pkg::CMD_SET;
          push_data.row  = nr[5:0];
          push_data.col  = nc[5:0];
        end
      end
      cat_pkg::OP_COMMIT: push_data.kind = cat_pkg::CMD_COMMIT;
      cat_pkg::OP_READ:   push_data.kind = cat_pkg::CMD_READ;
      default:            push_data.kind = cat_pkg::CMD_NONE;
    endcase
  end

endmodule

// ===== hdl/cat_queue.sv =====
// two entry command queue between front and back
module cat_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  cat_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output cat_pkg::cmd_t pop_data
);

  cat_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/cat_back.sv =====
// back end: flag map read-modify-write, commit scan, list read, result register
module cat_back #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cat_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  cat_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output cat_pkg::out_word_t out_data
);

  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FLAG  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_LIST  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [6:0] r, input logic [6:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  logic [2:0]         state_r, state_nxt;
  cat_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [12:0]        pending_r, pending_nxt;
  logic [12:0]        committed_r, committed_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [6:0]         scan_row_r, scan_row_nxt;
  logic [6:0]         scan_col_r, scan_col_nxt;
  logic               scan_done_r, scan_done_nxt;
  logic               p_vld_r, p_vld_nxt;
  logic [5:0]         p_row_r, p_row_nxt;
  logic [5:0]         p_col_r, p_col_nxt;
  logic [ADDR_W:0]    n_r, n_nxt;
  logic               out_valid_r, out_valid_nxt;
  cat_pkg::out_word_t out_data_r, out_data_nxt;

  logic               f_we, f_wdata, f_re, f_rdata;
  logic [ADDR_W-1:0]  f_waddr, f_raddr;
  logic               l_we, l_re;
  logic [ADDR_W-1:0]  l_waddr, l_raddr;
  logic [11:0]        l_wdata, l_rdata;
  logic               out_free, flip, entry_beyond;

  cat_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_flags (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
  );

  cat_ram #(.WIDTH(12), .DEPTH(CELL_COUNT)) u_list (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign clearing  = state_r == S_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign flip      = f_rdata != (cmd_r.kind == cat_pkg::CMD_SET);
  assign entry_beyond = ({1'b0, q_data.entry} >= committed_r) ||
                        (32'(q_data.entry) >= CELL_COUNT);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pending_nxt   = pending_r;
    committed_nxt = committed_r;
    clr_addr_nxt  = clr_addr_r;
    scan_row_nxt  = scan_row_r;
    scan_col_nxt  = scan_col_r;
    scan_done_nxt = scan_done_r;
    p_vld_nxt     = 1'b0;
    p_row_nxt     = p_row_r;
    p_col_nxt     = p_col_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop   = 1'b0;
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = 1'b0;
    f_re    = 1'b0;
    f_raddr = '0;
    l_we    = 1'b0;
    l_waddr = n_r[ADDR_W-1:0];
    l_wdata = {p_row_r, p_col_r};
    l_re    = 1'b0;
    l_raddr = ADDR_W'(q_data.entry);

    case (state_r)
      S_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          case (q_data.kind)
            cat_pkg::CMD_SET, cat_pkg::CMD_CLR: begin
              f_re      = 1'b1;
              f_raddr   = cell_addr({1'b0, q_data.row}, {1'b0, q_data.col});
              state_nxt = S_FLAG;
            end
            cat_pkg::CMD_COMMIT: begin
              committed_nxt = pending_r;
              scan_row_nxt  = 7'd0;
              scan_col_nxt  = 7'd0;
              scan_done_nxt = 1'b0;
              n_nxt         = '0;
              state_nxt     = S_SCAN;
            end
            cat_pkg::CMD_READ: begin
              if (entry_beyond) begin
                cmd_nxt.kind   = cat_pkg::CMD_NONE;
                cmd_nxt.status = cat_pkg::ST_ENTRY;
                state_nxt      = S_RESP;
              end else begin
                l_re      = 1'b1;
                state_nxt = S_LIST;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_FLAG: begin
        if (out_free) begin
          if (flip) begin
            f_we    = 1'b1;
            f_waddr = cell_addr({1'b0, cmd_r.row}, {1'b0, cmd_r.col});
            f_wdata = cmd_r.kind == cat_pkg::CMD_SET;
            pending_nxt = (cmd_r.kind == cat_pkg::CMD_SET) ? pending_r + 13'd1
                                                            : pending_r - 13'd1;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt.target_row    = cmd_r.row;
          out_data_nxt.target_col    = cmd_r.col;
          out_data_nxt.status        = cat_pkg::ST_OK;
          out_data_nxt.changed       = flip;
          out_data_nxt.pending_count = pending_nxt;
          out_data_nxt.current_count = committed_r;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        // flag read in the cycle before the list write
        if (p_vld_r && f_rdata) begin
          l_we  = 1'b1;
          n_nxt = n_r + (ADDR_W + 1)'(1);
        end
        if (!scan_done_r) begin
          f_re      = 1'b1;
          f_raddr   = cell_addr(scan_row_r, scan_col_r);
          p_vld_nxt = 1'b1;
          p_row_nxt = scan_row_r[5:0];
          p_col_nxt = scan_col_r[5:0];
          if (scan_col_r == cfg.cols - 7'd1) begin
            scan_col_nxt = 7'd0;
            scan_row_nxt = scan_row_r + 7'd1;
            if (scan_row_r == cfg.rows - 7'd1) begin
              scan_done_nxt = 1'b1;
            end
          end else begin
            scan_col_nxt = scan_col_r + 7'd1;
          end
        end else if (!p_vld_r) begin
          state_nxt = S_RESP;
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.target_row    = l_rdata[11:6];
          out_data_nxt.target_col    = l_rdata[5:0];
          out_data_nxt.status        = cat_pkg::ST_OK;
          out_data_nxt.changed       = 1'b0;
          out_data_nxt.pending_count = pending_r;
          out_data_nxt.current_count = committed_r;
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.target_row    = 6'd0;
          out_data_nxt.target_col    = 6'd0;
          out_data_nxt.status        = cmd_r.status;
          out_data_nxt.changed       = 1'b0;
          out_data_nxt.pending_count = pending_r;
          out_data_nxt.current_count = committed_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      pending_r   <= 13'd0;
      committed_r <= 13'd0;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
      scan_done_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pending_r   <= pending_nxt;
      committed_r <= committed_nxt;
      out_valid_r <= out_valid_nxt;
      p_vld_r     <= p_vld_nxt;
      scan_done_r <= scan_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    scan_row_r <= scan_row_nxt;
    scan_col_r <= scan_col_nxt;
    p_row_r    <= p_row_nxt;
    p_col_r    <= p_col_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hdl/ca_active_cell_tracker.sv =====
// top level of the active cell tracker: config registers, front, queue, back
// add, remove and add-neighbor: flag ram read when the back pops the word, then flag write and
//   result register, held while the result is stalled; the back takes no new word meanwhile
// read list entry: list ram registered read, then result register; status-only words: result only
// commit: one flag read per cell by the scan counter, each set cell appended to the list
// reset: synchronous, active low; then a clearing pass over all MAX_ROWS*MAX_COLS cells
//   of the flag ram during which in_ready stays low
module ca_active_cell_tracker #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cat_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cat_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_wdata
);

  // raw config registers
  logic [1:0] kind_r;
  logic       toroidal_r;
  logic [6:0] rows_r;
  logic [6:0] cols_r;

  cat_pkg::cfg_t cfg;
  cat_pkg::cmd_t push_data, pop_data;
  logic          push_valid, push_ready, pop_valid, pop;
  logic          clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= cat_pkg::KIND_MOORE;
      toroidal_r <= 1'b0;
      rows_r     <= 7'd64;
      cols_r     <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        cat_pkg::CFG_KIND:     kind_r     <= cfg_wdata[1:0];
        cat_pkg::CFG_TOROIDAL: toroidal_r <= cfg_wdata[0];
        cat_pkg::CFG_ROWS:     rows_r     <= cfg_wdata;
        cat_pkg::CFG_COLS:     cols_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // grid size in use: zero counts as one, clamp to the built size
  always_comb begin
    cfg.kind     = kind_r;
    cfg.toroidal = toroidal_r;
    if (rows_r == 7'd0) begin
      cfg.rows = 7'd1;
    end else if ({4'd0, rows_r} > 11'(MAX_ROWS)) begin
      cfg.rows = 7'(MAX_ROWS);
    end else begin
      cfg.rows = rows_r;
    end
    if (cols_r == 7'd0) begin
      cfg.cols = 7'd1;
    end else if ({4'd0, cols_r} > 11'(MAX_COLS)) begin
      cfg.cols = 7'(MAX_COLS);
    end else begin
      cfg.cols = cols_r;
    end
  end

  // front classifies each word into a command with its target cell
  cat_front u_front (
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data), .cfg(cfg),
    .busy(clearing), .push_valid(push_valid), .push_ready(push_ready),
    .push_data(push_data)
  );

  // short queue so the front keeps taking words while the back is busy
  cat_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_valid(push_valid), .push_ready(push_ready),
    .push_data(push_data), .pop_valid(pop_valid), .pop(pop), .pop_data(pop_data)
  );

  // back owns the flag map, the list and the counts
  cat_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(pop_valid), .q_data(pop_data),
    .q_pop(pop), .clearing(clearing), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

// ===== hdl/cat_checker.sv =====
// port level checks of the active cell tracker and their binding
module cat_props (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cat_pkg::out_word_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // rejected words carry no target and no flip
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != cat_pkg::ST_OK |->
      out_data.target_row == 6'd0 && out_data.target_col == 6'd0 && !out_data.changed)
    else $error("rejected word with target or flip");

  // no result right after reset
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // flag map clearing blocks input after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken during clearing");

endmodule

bind ca_active_cell_tracker cat_props u_cat_props (.*);
